// File: sv/tcpr_pkg.sv
// Shared types, constants and helpers for the text console with progress row.
// No dependencies; every other file imports this package.
package tcpr_pkg;

  localparam int COLUMNS = 32;
  localparam int ROWS = 16;
  localparam int CELLS = ROWS * COLUMNS;
  localparam int ADDR_W = $clog2(CELLS);
  localparam int COL_W = $clog2(COLUMNS);
  localparam int ROW_W = $clog2(ROWS);

  localparam int TEXT_LAST_ROW = ROWS - 2;
  localparam int BAR_ROW = ROWS - 1;
  localparam int COPY_CELLS = CELLS - (2 * COLUMNS);
  localparam int BAR_START = 8;
  localparam int BAR_SPAN = 15;

  localparam logic [7:0] FULL_BLOCK = 8'd7;
  localparam logic [7:0] SPACE = 8'h20;
  localparam logic [7:0] NEWLINE = 8'd10;

  localparam logic [5:0] BITS_MIN = 6'd7;
  localparam logic [5:0] BITS_MAX = 6'd32;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic [1:0] {
    REQ_PUT   = 2'd0,
    REQ_CLEAR = 2'd1,
    REQ_BAR   = 2'd2,
    REQ_READ  = 2'd3
  } req_t;

  // A request after classification by the front end.
  typedef struct packed {
    req_t              op;
    logic              newline;
    logic [7:0]        ch;
    logic [3:0]        full;
    logic [2:0]        part;
    logic [ADDR_W-1:0] addr;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] r,
                                                  input logic [COL_W-1:0] c);
    return ADDR_W'(int'(r) * COLUMNS + int'(c));
  endfunction

endpackage

// File: sv/tcpr_req_if.sv
// Request channel: valid/ready handshake carrying one console request.
// Depends on tcpr_pkg for the address width.
interface tcpr_req_if import tcpr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [1:0]        req_type;
  logic [7:0]        char_code;
  logic [31:0]       progress_value;
  logic [5:0]        progress_bits;
  logic [ADDR_W-1:0] cell_address;

  modport source (output valid, req_type, char_code, progress_value, progress_bits,
                  cell_address, input ready);
  modport sink (input valid, req_type, char_code, progress_value, progress_bits,
                cell_address, output ready);
endinterface

// File: sv/tcpr_res_if.sv
// Result channel: valid/ready handshake carrying read data and the cursor.
// Depends on tcpr_pkg for the cursor widths.
interface tcpr_res_if import tcpr_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [7:0]       read_data;
  logic [COL_W-1:0] cursor_col;
  logic [ROW_W-1:0] cursor_row;

  modport source (output valid, read_data, cursor_col, cursor_row, input ready);
  modport sink (input valid, read_data, cursor_col, cursor_row, output ready);
endinterface

// File: sv/tcpr_front.sv
// Front end: accepts requests and classifies them into commands for the queue.
// Depends on tcpr_pkg and tcpr_req_if.
module tcpr_front import tcpr_pkg::*; (
  tcpr_req_if.sink  req,
  input  q_stat_t   qs,
  input  logic      init_busy,
  output logic      push,
  output cmd_t      cmd
);

  logic [5:0]  bits_c;
  logic [31:0] sh_full;
  logic [31:0] sh_part;

  // Clamp the significant width, then pick the bar fields out of the value.
  always_comb begin
    if (req.progress_bits < BITS_MIN) begin
      bits_c = BITS_MIN;
    end else if (req.progress_bits > BITS_MAX) begin
      bits_c = BITS_MAX;
    end else begin
      bits_c = req.progress_bits;
    end
  end

  assign sh_full = req.progress_value >> (bits_c - 6'd4);
  assign sh_part = req.progress_value >> (bits_c - 6'd7);

  assign req.ready = !qs.full && !init_busy;
  assign push = req.valid && req.ready;

  always_comb begin
    cmd.op      = req_t'(req.req_type);
    cmd.newline = (req.char_code == NEWLINE);
    cmd.ch      = req.char_code;
    cmd.full    = sh_full[3:0];
    cmd.part    = sh_part[2:0];
    cmd.addr    = req.cell_address;
  end

endmodule

// File: sv/tcpr_queue.sv
// Short command queue between the front end and the back end.
// Depends on tcpr_pkg for cmd_t, q_stat_t and the depth.
module tcpr_queue import tcpr_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  cmd_t    din,
  input  logic    pop,
  output cmd_t    head,
  output q_stat_t qs
);

  cmd_t              slots [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  function automatic logic [QPTR_W-1:0] bump(input logic [QPTR_W-1:0] p);
    return (int'(p) == QDEPTH - 1) ? '0 : QPTR_W'(int'(p) + 1);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= bump(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= bump(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= din;
    end
  end

  assign head     = slots[rd_ptr];
  assign qs.empty = (count == '0);
  assign qs.full  = (int'(count) == QDEPTH);

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (!qs.full || pop))
    else $error("command queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> (count != '0))
    else $error("command queue read while empty");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (count == $past(count) + 1'b1))
    else $error("queue fill count did not follow a push");

endmodule

// File: sv/tcpr_back.sv
// Back end: sequencer over the screen store that carries out queued commands,
// keeps the cursor and holds the result register. Depends on tcpr_pkg, tcpr_res_if.
module tcpr_back import tcpr_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  cmd_t       head,
  input  q_stat_t    qs,
  output logic       pop,
  output logic       init_busy,
  tcpr_res_if.source res
);

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_COPY, S_BLANK, S_PUT, S_PAD, S_CLEAR, S_BAR, S_RDWAIT, S_FINISH
  } state_t;

  state_t            state;
  logic [ADDR_W-1:0] cnt;
  cmd_t              cur;
  logic [COL_W-1:0]  cur_col;
  logic [ROW_W-1:0]  cur_line;
  logic [7:0]        res_data;
  logic              out_valid;
  logic [7:0]        out_data;
  logic [COL_W-1:0]  out_col;
  logic [ROW_W-1:0]  out_row;

  logic [7:0]        mem [CELLS];
  logic [7:0]        rd_q;
  logic              we;
  logic [ADDR_W-1:0] wa;
  logic [7:0]        wd;
  logic [ADDR_W-1:0] ra;

  logic              col_last;
  logic              bar_last;
  logic [7:0]        bar_code;
  int                bar_col;

  assign col_last  = (int'(cur_col) == COLUMNS - 1);
  assign bar_col   = BAR_START + int'(cnt);
  assign bar_last  = (int'(cnt) == BAR_SPAN - 1 + ((cur.part != 3'd0) ? 1 : 0));
  assign pop       = (state == S_IDLE) && !qs.empty;
  assign init_busy = (state == S_INIT);

  always_comb begin
    if (int'(cnt) < int'(cur.full)) begin
      bar_code = FULL_BLOCK;
    end else if ((int'(cnt) == int'(cur.full)) && (cur.part != 3'd0)) begin
      bar_code = {5'd0, cur.part};
    end else begin
      bar_code = SPACE;
    end
  end

  // Store port control for each sequencer step.
  always_comb begin
    we = 1'b0;
    wa = cnt;
    wd = SPACE;
    ra = head.addr;
    case (state)
      S_INIT, S_CLEAR: begin
        we = 1'b1;
      end
      S_COPY: begin
        ra = ADDR_W'(int'(cnt) + COLUMNS);
        we = (cnt != '0);
        wa = cnt - 1'b1;
        wd = rd_q;
      end
      S_BLANK: begin
        we = 1'b1;
        wa = ADDR_W'(COPY_CELLS + int'(cnt));
      end
      S_PUT: begin
        we = !cur.newline;
        wa = cell_addr(cur_line, cur_col);
        wd = cur.ch;
      end
      S_PAD: begin
        we = 1'b1;
        wa = cell_addr(cur_line, cur_col);
      end
      S_BAR: begin
        we = (bar_col < COLUMNS);
        wa = ADDR_W'(BAR_ROW * COLUMNS + bar_col);
        wd = bar_code;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_q <= mem[ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT;
      cnt       <= '0;
      cur_col   <= '0;
      cur_line  <= '0;
      out_valid <= 1'b0;
    end else begin
      // In the finishing step the result register is reloaded below instead.
      if (out_valid && res.ready && (state != S_FINISH)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_INIT: begin
          cnt <= cnt + 1'b1;
          if (int'(cnt) == CELLS - 1) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (!qs.empty) begin
            cur      <= head;
            res_data <= 8'd0;
            cnt      <= '0;
            case (head.op)
              REQ_PUT: begin
                state <= (int'(cur_line) > TEXT_LAST_ROW) ? S_COPY : S_PUT;
              end
              REQ_CLEAR: begin
                cur_col  <= '0;
                cur_line <= '0;
                state    <= S_CLEAR;
              end
              REQ_BAR: begin
                state <= S_BAR;
              end
              default: begin
                state <= S_RDWAIT;
              end
            endcase
          end
        end
        S_COPY: begin
          if (int'(cnt) == COPY_CELLS) begin
            cnt   <= '0;
            state <= S_BLANK;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_BLANK: begin
          cnt <= cnt + 1'b1;
          if (int'(cnt) == COLUMNS - 1) begin
            cur_line <= cur_line - 1'b1;
            state    <= S_PUT;
          end
        end
        S_PUT: begin
          if (cur.newline) begin
            state <= S_PAD;
          end else begin
            state <= S_FINISH;
            if (col_last) begin
              cur_col  <= '0;
              cur_line <= cur_line + 1'b1;
            end else begin
              cur_col <= cur_col + 1'b1;
            end
          end
        end
        S_PAD: begin
          if (col_last) begin
            cur_col  <= '0;
            cur_line <= cur_line + 1'b1;
            state    <= S_FINISH;
          end else begin
            cur_col <= cur_col + 1'b1;
          end
        end
        S_CLEAR: begin
          cnt <= cnt + 1'b1;
          if (int'(cnt) == CELLS - 1) begin
            state <= S_FINISH;
          end
        end
        S_BAR: begin
          cnt <= cnt + 1'b1;
          if (bar_last) begin
            state <= S_FINISH;
          end
        end
        S_RDWAIT: begin
          res_data <= rd_q;
          state    <= S_FINISH;
        end
        S_FINISH: begin
          if (!out_valid || res.ready) begin
            out_valid <= 1'b1;
            out_data  <= res_data;
            out_col   <= cur_col;
            out_row   <= cur_line;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign res.valid     = out_valid;
  assign res.read_data = out_data;
  assign res.cursor_col = out_col;
  assign res.cursor_row = out_row;

  a_scroll_in_text: assert property (@(posedge clk) disable iff (rst)
    (we && (state == S_COPY || state == S_BLANK)) |-> (int'(wa) < BAR_ROW * COLUMNS))
    else $error("scroll wrote into the progress row");

  a_copy_offset: assert property (@(posedge clk) disable iff (rst)
    (we && state == S_COPY) |-> (int'(wa) + COLUMNS == int'($past(ra))))
    else $error("scroll copy wrote a cell other than the one read a row below");

  a_put_in_text: assert property (@(posedge clk) disable iff (rst)
    (state == S_PUT) |-> (int'(cur_line) <= TEXT_LAST_ROW))
    else $error("character placed with the cursor outside the text area");

endmodule

// File: sv/text_console_with_progress_row.sv
// Top level of the text console with progress row.
// Depends on tcpr_pkg, tcpr_req_if, tcpr_res_if, tcpr_front, tcpr_queue, tcpr_back.
//
// Usage: requests arrive on the req channel and are taken when valid and
// ready are both high. Each request gives exactly one result on the res
// channel: the cell contents for a read (zero otherwise) and the cursor
// position once the request has been carried out.
// The front end accepts and classifies requests into a two-entry queue; the
// back end is a sequencer over a single-port-write, single-port-read store
// of 512 bytes, and the number of store steps sets the latency. From
// acceptance to a valid result: a plain character and a read are the shortest,
// a progress row write also steps through its 15 or 16 cells, a newline steps
// through each padded column, and a put with the cursor on the progress row
// first scrolls the text area (448 copies, 32 blanks, one priming read).
// A clear walks all 512 cells.
// After rst (synchronous, active high) the store is cleared to spaces by a
// sweep over all 512 cells, during which req.ready stays low; the cursor is homed.
// The result sits in an output register; while the receiver holds res.ready
// low the back end waits with its next result, and the front end keeps
// accepting requests until the queue is full.
module text_console_with_progress_row import tcpr_pkg::*; (
  input logic        clk,
  input logic        rst,
  tcpr_req_if.sink   req,
  tcpr_res_if.source res
);

  logic    push;
  logic    pop;
  logic    init_busy;
  cmd_t    cmd_in;
  cmd_t    cmd_head;
  q_stat_t qs;

  // Classification: the progress fields are reduced to a block count and a
  // partial-block code here, so the back end only steps through cells.
  tcpr_front u_front (
    .req       (req),
    .qs        (qs),
    .init_busy (init_busy),
    .push      (push),
    .cmd       (cmd_in)
  );

  // The queue lets the front keep taking requests while the back end is
  // in a long scroll or clear, or waits on a stalled receiver.
  tcpr_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .din  (cmd_in),
    .pop  (pop),
    .head (cmd_head),
    .qs   (qs)
  );

  // The back end owns the screen store, the cursor and the result register.
  tcpr_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (cmd_head),
    .qs        (qs),
    .pop       (pop),
    .init_busy (init_busy),
    .res       (res)
  );

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for text_console_with_progress_row.
// Depends on tcpr_pkg, tcpr_req_if, tcpr_res_if and the block; it drives directed and random
// requests and checks every result against a behavioural model held in a small class.

module tb_top;
  import tcpr_pkg::*;

  // The longest quiet stretch in a correct run is the reset sweep or a clear over all cells,
  // with the receiver stalling on top, so STALL_LIMIT below is generous.
  localparam int STALL_LIMIT = 4000;
  localparam int SETTLE_CYCLES = 520;
  localparam int RANDOM_PER_PHASE = 385;
  localparam int MAX_REPORTED = 10;

  typedef struct {
    req_t              op;
    logic [7:0]        char_code;
    logic [31:0]       progress_value;
    logic [5:0]        progress_bits;
    logic [ADDR_W-1:0] cell_address;
  } console_req_t;

  typedef struct {
    logic [7:0]       read_data;
    logic [COL_W-1:0] cursor_col;
    logic [ROW_W-1:0] cursor_row;
  } console_res_t;

  // Tracks the screen contents and the cursor as the block should see them, and holds the
  // results that are owed for requests already taken.
  class console_tracker;
    logic [7:0]   screen [CELLS];
    int unsigned  col;
    int unsigned  row;
    console_res_t outcomes_due[$];
    int           mismatches;
    int           checked;
    int           op_seen [4];
    int           scrolls;

    function new();
      blank_screen();
      mismatches = 0;
      checked = 0;
      scrolls = 0;
      foreach (op_seen[k]) op_seen[k] = 0;
    endfunction

    function void blank_screen();
      foreach (screen[k]) screen[k] = SPACE;
      col = 0;
      row = 0;
    endfunction

    // Text rows move up by one; the progress row is left alone.
    function void shift_text_up();
      for (int k = 0; k < TEXT_LAST_ROW * COLUMNS; k++) screen[k] = screen[k + COLUMNS];
      for (int k = 0; k < COLUMNS; k++) screen[TEXT_LAST_ROW * COLUMNS + k] = SPACE;
      scrolls++;
    endfunction

    function void store_char(logic [7:0] c);
      while (row > TEXT_LAST_ROW) begin
        shift_text_up();
        row--;
      end
      if (col >= COLUMNS) col = 0;
      if (c == NEWLINE) begin
        while (col < COLUMNS) begin
          screen[row * COLUMNS + col] = SPACE;
          col++;
        end
      end else begin
        screen[row * COLUMNS + col] = c;
        col++;
      end
      if (col >= COLUMNS) begin
        col = 0;
        row++;
      end
    endfunction

    function void put_bar_cell(int unsigned pos, logic [7:0] code);
      if (pos < COLUMNS) screen[BAR_ROW * COLUMNS + pos] = code;
    endfunction

    function void paint_progress(logic [31:0] value, logic [5:0] bits);
      int unsigned nbits, full, part, pos, i;
      nbits = bits;
      if (nbits < BITS_MIN) nbits = BITS_MIN;
      if (nbits > BITS_MAX) nbits = BITS_MAX;
      full = (value >> (nbits - 4)) & 15;
      part = (value >> (nbits - 7)) & 7;
      pos = BAR_START;
      for (i = 0; i < full; i++) begin
        put_bar_cell(pos, FULL_BLOCK);
        pos++;
      end
      if (part != 0) begin
        put_bar_cell(pos, 8'(part));
        pos++;
      end
      while (i < BAR_SPAN) begin
        put_bar_cell(pos, SPACE);
        pos++;
        i++;
      end
    endfunction

    function void note_request(console_req_t r);
      console_res_t e;
      e.read_data = 8'h00;
      op_seen[r.op]++;
      case (r.op)
        REQ_PUT:   store_char(r.char_code);
        REQ_CLEAR: blank_screen();
        REQ_BAR:   paint_progress(r.progress_value, r.progress_bits);
        REQ_READ: begin
          if (r.cell_address < CELLS) e.read_data = screen[r.cell_address];
        end
        default: ;
      endcase
      e.cursor_col = COL_W'(col);
      e.cursor_row = ROW_W'(row);
      outcomes_due.push_back(e);
    endfunction

    function void check_result(console_res_t got);
      console_res_t e;
      if (outcomes_due.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTED)
          $display("Result with nothing owed: data %02h col %0d row %0d",
                   got.read_data, got.cursor_col, got.cursor_row);
        return;
      end
      e = outcomes_due.pop_front();
      checked++;
      if (got.read_data !== e.read_data || got.cursor_col !== e.cursor_col ||
          got.cursor_row !== e.cursor_row) begin
        mismatches++;
        if (mismatches <= MAX_REPORTED)
          $display("Mismatch on result %0d: expected data %02h col %0d row %0d, got data %02h col %0d row %0d",
                   checked, e.read_data, e.cursor_col, e.cursor_row,
                   got.read_data, got.cursor_col, got.cursor_row);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   send_idle_pct;
  int   recv_idle_pct;
  int   stall_cycles;

  console_tracker sb;

  tcpr_req_if req_ch ();
  tcpr_res_if res_ch ();

  text_console_with_progress_row uut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .res(res_ch)
  );

  always #5 clk = ~clk;

  // The receiver drops ready at random, at the rate of the current phase.
  always @(posedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= ($urandom_range(99, 0) >= recv_idle_pct);
    end
  end

  // Both channels are watched at the clock edge. Every signal that the block drives changes
  // only after the edge, so the values seen here are the ones that the handshake used.
  // The watchdog counts edges at which no request and no result changed hands.
  always @(posedge clk) begin
    if (!rst && req_ch.valid && req_ch.ready)
      sb.note_request('{req_t'(req_ch.req_type), req_ch.char_code, req_ch.progress_value,
                        req_ch.progress_bits, req_ch.cell_address});
    if (!rst && res_ch.valid && res_ch.ready)
      sb.check_result('{res_ch.read_data, res_ch.cursor_col, res_ch.cursor_row});
    if (rst || (req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("Timeout: no request or result moved for %0d cycles", STALL_LIMIT);
      $display("[text_console_with_progress_row] ERROR");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  function automatic console_req_t make_request(req_t op, logic [7:0] c, logic [31:0] v,
                                                logic [5:0] b, logic [ADDR_W-1:0] a);
    console_req_t r;
    r.op = op;
    r.char_code = c;
    r.progress_value = v;
    r.progress_bits = b;
    r.cell_address = a;
    return r;
  endfunction

  // Mostly text, with newlines often enough that the cursor reaches the bottom and the text
  // area scrolls many times between the rare clears. Unused fields carry random noise.
  function automatic console_req_t random_request();
    console_req_t r;
    int pick;
    int sub;
    r = make_request(REQ_READ, 8'($urandom_range(255, 0)), $urandom(),
                     6'($urandom_range(63, 0)), ADDR_W'($urandom_range(CELLS - 1, 0)));
    pick = $urandom_range(999, 0);
    sub = $urandom_range(99, 0);
    if (pick < 700) begin
      r.op = REQ_PUT;
      if (sub < 20) r.char_code = NEWLINE;
      else if (sub < 80) r.char_code = 8'($urandom_range(8'h7E, 8'h20));
    end else if (pick < 820) begin
      r.op = REQ_BAR;
      // Most widths lie in the legal range; the rest span all 6-bit values and test the clamping at both ends.
      if (sub < 70) r.progress_bits = 6'($urandom_range(BITS_MAX, BITS_MIN));
    end else if (pick < 997) begin
      r.op = REQ_READ;
      if (sub < 40) r.cell_address = ADDR_W'(BAR_ROW * COLUMNS + $urandom_range(COLUMNS - 1, 0));
    end else begin
      r.op = REQ_CLEAR;
    end
    return r;
  endfunction

  // Idle gaps come before the request is raised; once raised, valid stays high until the
  // request is taken. Only one assignment to valid is made in any time step.
  task automatic send_request(console_req_t r);
    while ($urandom_range(99, 0) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.req_type <= r.op;
    req_ch.char_code <= r.char_code;
    req_ch.progress_value <= r.progress_value;
    req_ch.progress_bits <= r.progress_bits;
    req_ch.cell_address <= r.cell_address;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
  endtask

  task automatic wait_until_drained();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.outcomes_due.size() != 0) @(posedge clk);
  endtask

  initial begin
    int phase;
    sb = new();
    req_ch.valid = 1'b0;
    req_ch.req_type = REQ_PUT;
    req_ch.char_code = 8'h00;
    req_ch.progress_value = 32'h0;
    req_ch.progress_bits = 6'h0;
    req_ch.cell_address = '0;
    res_ch.ready = 1'b0;
    send_idle_pct = 14;
    recv_idle_pct = 61;
    stall_cycles = 0;

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed part. The last cell of the progress row should still hold a space from the
    // reset sweep; then the extreme byte values go into the first text row.
    send_request(make_request(REQ_READ, 8'h00, 32'h0, 6'd0, ADDR_W'(CELLS - 1)));
    send_request(make_request(REQ_PUT, 8'h41, 32'h0, 6'd0, '0));
    send_request(make_request(REQ_PUT, 8'h00, 32'h0, 6'd0, '0));
    send_request(make_request(REQ_PUT, 8'hFF, 32'h0, 6'd0, '0));
    // Newlines pad the rest of each row and walk the cursor down onto the progress row;
    // the character after them has to scroll the text area first.
    repeat (TEXT_LAST_ROW + 1)
      send_request(make_request(REQ_PUT, NEWLINE, 32'h0, 6'd0, '0));
    send_request(make_request(REQ_PUT, 8'h7E, 32'h0, 6'd0, '0));
    // Progress widths below and above the legal range, with empty and full bars; the full
    // bar ends on a partial block whose cell is then read back.
    send_request(make_request(REQ_BAR, 8'h00, 32'h0, 6'd0, '0));
    send_request(make_request(REQ_BAR, 8'h00, 32'hFFFF_FFFF, 6'd63, '0));
    send_request(make_request(REQ_READ, 8'h00, 32'h0, 6'd0,
                              ADDR_W'(BAR_ROW * COLUMNS + BAR_START + BAR_SPAN)));
    send_request(make_request(REQ_CLEAR, 8'h00, 32'h0, 6'd0, '0));
    send_request(make_request(REQ_READ, 8'h00, 32'h0, 6'd0,
                              ADDR_W'(BAR_ROW * COLUMNS + BAR_START)));

    // Random part in three phases: a slow receiver, then a slow sender, then no idling.
    // Between phases the sender holds back until every owed result has come.
    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 14;
          recv_idle_pct = 61;
        end
        1: begin
          send_idle_pct = 61;
          recv_idle_pct = 14;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      if (phase != 0) wait_until_drained();
      repeat (RANDOM_PER_PHASE) send_request(random_request());
    end

    wait_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Run covered %0d puts, %0d clears, %0d progress rows and %0d reads.",
             sb.op_seen[REQ_PUT], sb.op_seen[REQ_CLEAR], sb.op_seen[REQ_BAR],
             sb.op_seen[REQ_READ]);
    $display("%0d results checked, %0d text scrolls predicted, %0d mismatches.",
             sb.checked, sb.scrolls, sb.mismatches);
    if (sb.mismatches == 0 && sb.outcomes_due.size() == 0) begin
      $display("[text_console_with_progress_row] OK");
    end else begin
      $display("[text_console_with_progress_row] ERROR");
    end
    $finish;
  end

endmodule
